FILE: hdl/fqpd_pkg.sv
// shared types, codes and default sizes of the four-queue priority dispatcher
package fqpd_pkg;

   localparam int unsigned QUEUE_DEPTH   = 16;
   localparam int unsigned PRIORITY_BITS = 8;
   localparam int unsigned ID_BITS       = 16;
   localparam int unsigned NUM_QUEUES    = 4;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic        command;
      logic [15:0] process_id;
      logic [7:0]  priority_req;
      logic        real_time;
      logic [1:0]  queue_select;
   } req_type;

   typedef struct packed {
      logic [1:0]  queue_used;
      logic [15:0] out_process_id;
      logic [7:0]  out_priority;
      logic [1:0]  status;
      logic [4:0]  queue_length;
   } rsp_type;

endpackage

FILE: hdl/fqpd_ram.sv
// generic simple dual-port ram, one write port and one registered read port
module fqpd_ram #(
   parameter int unsigned WIDTH = 24,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/four_queue_priority_dispatcher_top.sv
// top level of the four-queue priority dispatcher: control, queue lengths and entry memory
//
// Four sorted queues share one entry memory; each queue owns QUEUE_DEPTH consecutive slots
// kept in priority order with the head at slot 0, and the queue lengths sit in flip-flops.
// A command is taken when start is high and busy is low. An insert walks from the tail of the
// chosen queue toward the head, one memory read and one write per cycle, moving each entry
// of larger priority up by one slot, and busy stays high until the new entry is written. A
// remove streams the queue through the memory to close the gap at the head and keeps busy
// high until the queue has been streamed. An insert into a full queue or a remove from an
// empty one is answered without touching the memory and busy stays low. Every command gives
// exactly one transaction on rsp_item, shown for one cycle with rsp_strobe high, in the cycle
// in which busy drops or, when busy stayed low, in the cycle after the command is taken; the
// receiver cannot stall, and the next command may be started in that same cycle. The memory
// needs no clearing after reset.
module four_queue_priority_dispatcher_top #(
   parameter int unsigned QUEUE_DEPTH   = fqpd_pkg::QUEUE_DEPTH,
   parameter int unsigned PRIORITY_BITS = fqpd_pkg::PRIORITY_BITS,
   parameter int unsigned ID_BITS       = fqpd_pkg::ID_BITS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  fqpd_pkg::req_type req_item,
   output logic              rsp_strobe,
   output fqpd_pkg::rsp_type rsp_item
);

   localparam int unsigned IDX_W   = $clog2(QUEUE_DEPTH);
   localparam int unsigned LEN_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned ENTRY_W = PRIORITY_BITS + ID_BITS;
   localparam int unsigned ADDR_W  = IDX_W + 2;
   localparam int unsigned RAM_D   = fqpd_pkg::NUM_QUEUES << IDX_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_INSERT,
      ST_REMOVE
   } state_type;

   state_type            state_ff;
   logic [1:0]           q_ff;
   logic [IDX_W-1:0]     idx_ff;
   logic [ENTRY_W-1:0]   new_entry_ff;
   logic [ENTRY_W-1:0]   head_ff;
   logic [LEN_W-1:0]     len_ff [fqpd_pkg::NUM_QUEUES];
   logic                 rsp_strobe_ff;
   fqpd_pkg::rsp_type    rsp_item_ff;

   logic                 accept;
   logic [1:0]           pair_base;
   logic [1:0]           q_ins;
   logic [1:0]           q_acc;
   logic [LEN_W-1:0]     len_acc;
   logic [LEN_W-1:0]     len_cur;
   logic [ENTRY_W-1:0]   rd_data;
   logic [ENTRY_W-1:0]   head_sel;
   logic [PRIORITY_BITS-1:0] rd_prio;
   logic [PRIORITY_BITS-1:0] new_prio;
   logic                 shift;
   logic                 last;
   logic                 wr_en;
   logic [ADDR_W-1:0]    wr_addr;
   logic [ENTRY_W-1:0]   wr_data;
   logic [ADDR_W-1:0]    rd_addr;

   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE);
   assign pair_base = {req_item.real_time, 1'b0};
   // second queue of the pair only when strictly shorter
   assign q_ins     = (len_ff[pair_base | 2'd1] < len_ff[pair_base]) ?
                      (pair_base | 2'd1) : pair_base;
   assign q_acc     = (req_item.command == fqpd_pkg::CMD_INSERT) ? q_ins : req_item.queue_select;
   assign len_acc   = len_ff[q_acc];
   assign len_cur   = len_ff[q_ff];

   assign rd_prio   = rd_data[ENTRY_W-1:ID_BITS];
   assign new_prio  = new_entry_ff[ENTRY_W-1:ID_BITS];
   // strictly greater moves up, equal stays ahead to keep arrival order
   assign shift     = (idx_ff != '0) && (rd_prio > new_prio);
   assign last      = (LEN_W'(idx_ff) == len_cur - LEN_W'(1));
   assign head_sel  = (idx_ff == '0) ? rd_data : head_ff;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = {q_ff, idx_ff};
      wr_data = rd_data;
      rd_addr = {q_ff, IDX_W'(idx_ff + IDX_W'(1))};
      case (state_ff)
         ST_IDLE: begin
            if (req_item.command == fqpd_pkg::CMD_INSERT) begin
               rd_addr = {q_acc, IDX_W'(len_acc - LEN_W'(1))};
            end else begin
               rd_addr = {q_acc, IDX_W'(0)};
            end
         end
         ST_INSERT: begin
            wr_en   = 1'b1;
            wr_data = shift ? rd_data : new_entry_ff;
            rd_addr = {q_ff, IDX_W'(idx_ff - IDX_W'(2))};
         end
         ST_REMOVE: begin
            // idx_ff is the slot whose data arrives now; it moves down one slot
            wr_en   = (idx_ff != '0);
            wr_addr = {q_ff, IDX_W'(idx_ff - IDX_W'(1))};
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   fqpd_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (RAM_D)
   ) u_entry_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_strobe_ff <= 1'b0;
         for (int i = 0; i < fqpd_pkg::NUM_QUEUES; i++) begin
            len_ff[i] <= '0;
         end
      end else begin
         rsp_strobe_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  q_ff         <= q_acc;
                  new_entry_ff <= {PRIORITY_BITS'(req_item.priority_req),
                                   ID_BITS'(req_item.process_id)};
                  rsp_item_ff.queue_used     <= q_acc;
                  rsp_item_ff.out_process_id <= '0;
                  rsp_item_ff.out_priority   <= '0;
                  if (req_item.command == fqpd_pkg::CMD_INSERT) begin
                     if (len_acc == LEN_W'(QUEUE_DEPTH)) begin
                        rsp_strobe_ff            <= 1'b1;
                        rsp_item_ff.status       <= fqpd_pkg::STATUS_FULL;
                        rsp_item_ff.queue_length <= 5'(len_acc);
                     end else begin
                        idx_ff   <= IDX_W'(len_acc);
                        state_ff <= ST_INSERT;
                     end
                  end else begin
                     if (len_acc == '0) begin
                        rsp_strobe_ff            <= 1'b1;
                        rsp_item_ff.status       <= fqpd_pkg::STATUS_EMPTY;
                        rsp_item_ff.queue_length <= '0;
                     end else begin
                        idx_ff   <= '0;
                        state_ff <= ST_REMOVE;
                     end
                  end
               end
            end
            ST_INSERT: begin
               if (shift) begin
                  idx_ff <= idx_ff - IDX_W'(1);
               end else begin
                  len_ff[q_ff]             <= len_cur + LEN_W'(1);
                  rsp_strobe_ff            <= 1'b1;
                  rsp_item_ff.status       <= fqpd_pkg::STATUS_OK;
                  rsp_item_ff.queue_length <= 5'(len_cur + LEN_W'(1));
                  state_ff                 <= ST_IDLE;
               end
            end
            ST_REMOVE: begin
               if (idx_ff == '0) begin
                  head_ff <= rd_data;
               end
               if (last) begin
                  len_ff[q_ff]               <= len_cur - LEN_W'(1);
                  rsp_strobe_ff              <= 1'b1;
                  rsp_item_ff.out_process_id <= 16'(head_sel[ID_BITS-1:0]);
                  rsp_item_ff.out_priority   <= 8'(head_sel[ENTRY_W-1:ID_BITS]);
                  rsp_item_ff.status         <= fqpd_pkg::STATUS_OK;
                  rsp_item_ff.queue_length   <= 5'(len_cur - LEN_W'(1));
                  state_ff                   <= ST_IDLE;
               end else begin
                  idx_ff <= idx_ff + IDX_W'(1);
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

endmodule

FILE: tb/tb_four_queue_priority_dispatcher_top.sv
// testbench of the four-queue priority dispatcher: directed and random commands against a predictor
module tb_four_queue_priority_dispatcher_top;

   localparam int unsigned CYCLE_LIMIT  = 500000;
   localparam int unsigned DRAIN_CYCLES = 2 * fqpd_pkg::QUEUE_DEPTH + 8;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   fqpd_pkg::req_type req_item;
   logic              rsp_strobe;
   fqpd_pkg::rsp_type rsp_item;

   // mirror of the four sorted queues, head at slot 0
   logic [15:0] mirror_id   [fqpd_pkg::NUM_QUEUES][fqpd_pkg::QUEUE_DEPTH];
   logic [7:0]  mirror_prio [fqpd_pkg::NUM_QUEUES][fqpd_pkg::QUEUE_DEPTH];
   int unsigned mirror_len  [fqpd_pkg::NUM_QUEUES];

   fqpd_pkg::rsp_type awaited_rsp[$];
   int unsigned failures    = 0;
   int unsigned cycle_count = 0;

   four_queue_priority_dispatcher_top dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("four_queue_priority_dispatcher_top regression: fail");
         $finish;
      end
   end

   // work out the answer to one command and update the mirror
   task automatic dispatch_predict(input fqpd_pkg::req_type c, output fqpd_pkg::rsp_type r);
      int unsigned q;
      int unsigned len;
      int unsigned pos;
      r = '0;
      if (c.command == fqpd_pkg::CMD_INSERT) begin
         q = c.real_time ? 2 : 0;
         // second queue of the pair only when strictly shorter
         if (mirror_len[q + 1] < mirror_len[q]) q = q + 1;
         len = mirror_len[q];
         r.queue_used = 2'(q);
         if (len >= fqpd_pkg::QUEUE_DEPTH) begin
            r.status       = fqpd_pkg::STATUS_FULL;
            r.queue_length = 5'(len);
         end else begin
            // first slot with a strictly larger priority keeps arrival order
            pos = len;
            for (int i = int'(len) - 1; i >= 0; i--)
               if (mirror_prio[q][i] > c.priority_req) pos = unsigned'(i);
            for (int i = int'(len); i > int'(pos); i--) begin
               mirror_id[q][i]   = mirror_id[q][i - 1];
               mirror_prio[q][i] = mirror_prio[q][i - 1];
            end
            mirror_id[q][pos]   = c.process_id;
            mirror_prio[q][pos] = c.priority_req;
            mirror_len[q]       = len + 1;
            r.status            = fqpd_pkg::STATUS_OK;
            r.queue_length      = 5'(len + 1);
         end
      end else begin
         q            = c.queue_select;
         len          = mirror_len[q];
         r.queue_used = c.queue_select;
         if (len == 0) begin
            r.status       = fqpd_pkg::STATUS_EMPTY;
            r.queue_length = '0;
         end else begin
            r.out_process_id = mirror_id[q][0];
            r.out_priority   = mirror_prio[q][0];
            for (int i = 1; i < int'(len); i++) begin
               mirror_id[q][i - 1]   = mirror_id[q][i];
               mirror_prio[q][i - 1] = mirror_prio[q][i];
            end
            mirror_len[q]  = len - 1;
            r.status       = fqpd_pkg::STATUS_OK;
            r.queue_length = 5'(len - 1);
         end
      end
   endtask

   task automatic send_command(input fqpd_pkg::req_type c);
      fqpd_pkg::rsp_type r;
      @(negedge clock);
      start    <= 1'b1;
      req_item <= c;
      do @(posedge clock); while (busy);
      dispatch_predict(c, r);
      awaited_rsp.push_back(r);
   endtask

   task automatic idle_cycles(input int unsigned n);
      repeat (n) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   task automatic random_pause(input bit quiet);
      int unsigned pick;
      pick = $urandom_range(99);
      if (quiet || pick < 55) return;
      if (pick < 90) idle_cycles($urandom_range(3, 1));
      else idle_cycles($urandom_range(40, 8));
   endtask

   function automatic fqpd_pkg::req_type make_insert(input logic [15:0] id,
                                                     input logic [7:0] prio,
                                                     input logic rt);
      fqpd_pkg::req_type c;
      c.command      = fqpd_pkg::CMD_INSERT;
      c.process_id   = id;
      c.priority_req = prio;
      c.real_time    = rt;
      c.queue_select = 2'($urandom_range(3));
      return c;
   endfunction

   function automatic fqpd_pkg::req_type make_remove(input logic [1:0] q);
      fqpd_pkg::req_type c;
      c.command      = fqpd_pkg::CMD_REMOVE;
      c.process_id   = 16'($urandom);
      c.priority_req = 8'($urandom);
      c.real_time    = 1'($urandom);
      c.queue_select = q;
      return c;
   endfunction

   task automatic check_field(input string label, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, label, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      fqpd_pkg::rsp_type want;
      if (!reset && rsp_strobe) begin
         if (awaited_rsp.size() == 0) begin
            $display("%0t: unexpected transaction, expected none actual %0h", $time, rsp_item);
            failures++;
         end else begin
            want = awaited_rsp.pop_front();
            check_field("queue_used", want.queue_used, rsp_item.queue_used);
            check_field("out_process_id", want.out_process_id, rsp_item.out_process_id);
            check_field("out_priority", want.out_priority, rsp_item.out_priority);
            check_field("status", want.status, rsp_item.status);
            check_field("queue_length", want.queue_length, rsp_item.queue_length);
         end
      end
   end

   task automatic test_empty_removes();
      for (int q = 0; q < fqpd_pkg::NUM_QUEUES; q++) begin
         send_command(make_remove(2'(q)));
         random_pause(1'b0);
      end
   endtask

   // extremes, pair balancing and equal priorities leaving in arrival order
   task automatic test_order_and_extremes();
      send_command(make_insert(16'h0000, 8'hff, 1'b0));
      send_command(make_insert(16'hffff, 8'h00, 1'b0));
      send_command(make_insert(16'h1111, 8'h07, 1'b0));
      random_pause(1'b0);
      send_command(make_insert(16'h2222, 8'h07, 1'b0));
      send_command(make_insert(16'h3333, 8'h07, 1'b0));
      send_command(make_insert(16'h4444, 8'h00, 1'b0));
      send_command(make_insert(16'haaaa, 8'h80, 1'b1));
      random_pause(1'b0);
      send_command(make_insert(16'h5555, 8'h80, 1'b1));
      send_command(make_insert(16'h0f0f, 8'h80, 1'b1));
      repeat (4) send_command(make_remove(2'd0));
      repeat (4) begin
         send_command(make_remove(2'd1));
         random_pause(1'b0);
      end
      repeat (3) send_command(make_remove(2'd2));
      repeat (2) send_command(make_remove(2'd3));
   endtask

   // phases of varying insert share so the queues fill up and drain again
   task automatic test_random_traffic(input int unsigned count);
      int unsigned       share [4] = '{5, 40, 60, 95};
      int unsigned       pct;
      bit                quiet;
      fqpd_pkg::req_type c;
      logic [7:0]        prio;
      for (int unsigned n = 0; n < count; n++) begin
         if (n % 100 == 0) begin
            pct   = share[$urandom_range(3)];
            quiet = ($urandom_range(3) == 0);
         end
         case ($urandom_range(3))
            0: prio = 8'($urandom_range(3));
            1: prio = $urandom_range(1) ? 8'hff : 8'h00;
            default: prio = 8'($urandom);
         endcase
         if ($urandom_range(99) < pct)
            c = make_insert(16'($urandom), prio, 1'($urandom));
         else
            c = make_remove(2'($urandom_range(3)));
         send_command(c);
         random_pause(quiet);
      end
   endtask

   initial begin
      reset    = 1'b1;
      start    = 1'b0;
      req_item = '0;
      foreach (mirror_len[q]) mirror_len[q] = 0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      test_empty_removes();
      test_order_and_extremes();
      test_random_traffic(1625);

      idle_cycles(1);
      while (awaited_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("four_queue_priority_dispatcher_top regression: pass");
      end else begin
         $display("four_queue_priority_dispatcher_top regression: fail");
      end
      $finish;
   end

endmodule

FILE: filelist.f
hdl/fqpd_pkg.sv
hdl/fqpd_ram.sv
hdl/four_queue_priority_dispatcher_top.sv
tb/tb_four_queue_priority_dispatcher_top.sv
